FILE: design/olar_pkg.sv
// ----------------------------------------------------------------------------
// olar_pkg
// Shared types and constants for the ordered list block.
// ----------------------------------------------------------------------------
package olar_pkg;

  localparam int Capacity  = 16;
  localparam int AddrW     = $clog2(Capacity);
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int ValW      = 32;
  localparam int CountOutW = 5;
  localparam int OpW       = 2;
  localparam int StatW     = 2;

  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

FILE: design/ordered_list_append_remove.sv
// ----------------------------------------------------------------------------
// ordered_list_append_remove
// Ordered list of signed words: append at tail, remove head, remove first
// matching value. One result item per input item.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// in      | in_valid / in_stall  | op, item_value
// out     | out_valid / out_stall| status, entry_count, head_value, tail_value
//
// Append writes the new tail into the store unless the list is full; remove
// head and remove value walk the store with one read port and one compare
// unit, an entry a cycle, moving kept entries down behind a removed one.
// Unused op codes leave the list unchanged. The next item is taken once the
// result is in the output register, even while that result is stalled.
// Reset (rst, synchronous) empties the list; the store itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_list_append_remove (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [olar_pkg::OpW-1:0]       op,
  input  olar_pkg::val_t                 item_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [olar_pkg::StatW-1:0]     status,
  output logic [olar_pkg::CountOutW-1:0] entry_count,
  output olar_pkg::val_t                 head_value,
  output olar_pkg::val_t                 tail_value
);
  import olar_pkg::*;

  state_t             state, state_next;
  logic [CntW-1:0]    count, count_next;
  val_t               head, head_next;
  val_t               tail, tail_next;
  op_t                op_r, op_r_next;
  val_t               val_r, val_r_next;
  status_t            st, st_next;
  logic [CntW-1:0]    idx, idx_next;
  logic [AddrW-1:0]   pos, pos_next;
  logic               rvalid, rvalid_next;
  logic               found, found_next;
  logic               kept_seen, kept_seen_next;

  logic               we;
  logic [AddrW-1:0]   waddr;
  val_t               wdata;
  logic [AddrW-1:0]   raddr;
  val_t               rdata;
  logic               issue;
  logic               match;
  logic               load_out;

  olar_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign raddr    = idx[AddrW-1:0];
  assign issue    = (state == S_SCAN) && (idx < count);
  assign match    = (op_r == OP_POP) ? (pos == '0) : (rdata == val_r);
  assign load_out = (state == S_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    state_next     = state;
    count_next     = count;
    head_next      = head;
    tail_next      = tail;
    op_r_next      = op_r;
    val_r_next     = val_r;
    st_next        = st;
    idx_next       = idx;
    pos_next       = pos;
    rvalid_next    = 1'b0;
    found_next     = found;
    kept_seen_next = kept_seen;
    we             = 1'b0;
    waddr          = count[AddrW-1:0];
    wdata          = val_r;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r_next      = op_t'(op);
          val_r_next     = item_value;
          st_next        = ST_MISS;
          idx_next       = '0;
          found_next     = 1'b0;
          kept_seen_next = 1'b0;
          unique case (op_t'(op))
            OP_APPEND:         state_next = S_APPEND;
            OP_POP, OP_DELETE: state_next = S_SCAN;
            default:           state_next = S_FINISH;
          endcase
        end
      end

      S_APPEND: begin
        if (count == CntW'(Capacity)) begin
          st_next = ST_FULL;
        end else begin
          we         = 1'b1;
          tail_next  = val_r;
          if (count == '0) begin
            head_next = val_r;
          end
          count_next = count + 1'b1;
          st_next    = ST_DONE;
        end
        state_next = S_FINISH;
      end

      S_SCAN: begin
        // read entry idx while judging entry pos read the cycle before
        if (issue) begin
          idx_next    = idx + 1'b1;
          pos_next    = idx[AddrW-1:0];
          rvalid_next = 1'b1;
        end
        if (rvalid) begin
          if (!found && match) begin
            found_next = 1'b1;
          end else begin
            if (!kept_seen) begin
              head_next      = rdata;
              kept_seen_next = 1'b1;
            end
            tail_next = rdata;
            if (found) begin
              we    = 1'b1;
              waddr = pos - 1'b1;
              wdata = rdata;
            end
          end
        end else if (!issue) begin
          if (found) begin
            count_next = count - 1'b1;
            st_next    = ST_DONE;
          end
          if (!kept_seen) begin
            head_next = '0;
            tail_next = '0;
          end
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      tail      <= '0;
      rvalid    <= 1'b0;
      found     <= 1'b0;
      kept_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head      <= head_next;
      tail      <= tail_next;
      rvalid    <= rvalid_next;
      found     <= found_next;
      kept_seen <= kept_seen_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_r_next;
    val_r <= val_r_next;
    st    <= st_next;
    idx   <= idx_next;
    pos   <= pos_next;
    if (load_out) begin
      status      <= st;
      entry_count <= CountOutW'(count);
      head_value  <= head;
      tail_value  <= tail;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> idx <= count)
    else $error("scan index ran past the entry count");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside the finish step");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == CountOutW'(Capacity))
    else $error("full status with list not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_count == '0 |-> head_value == '0 && tail_value == '0)
    else $error("empty list reports nonzero head or tail");

endmodule

FILE: design/olar_ram.sv
// ----------------------------------------------------------------------------
// olar_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module olar_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [olar_pkg::AddrW-1:0] waddr,
  input  olar_pkg::val_t             wdata,
  input  logic [olar_pkg::AddrW-1:0] raddr,
  output olar_pkg::val_t             rdata
);
  import olar_pkg::*;

  val_t mem [Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: bench/tb_ordered_list_append_remove.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_append_remove
// Self-checking bench for the ordered list block. A queue-based model of the
// list predicts status, count, head and tail for every accepted item. The
// expected results are compared with the output channel in order. Directed
// items cover the empty list, extreme values, a full store and first-match
// removal. Random traffic then fills and drains the list with small value
// pools so that removals by value hit. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_ordered_list_append_remove;
  import olar_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int RandomSize = 1920;

  typedef struct {
    logic [StatW-1:0]     status;
    logic [CountOutW-1:0] count;
    val_t                 head;
    val_t                 tail;
  } list_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OpW-1:0]       op = OP_APPEND;
  val_t                 item_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [StatW-1:0]     status;
  logic [CountOutW-1:0] entry_count;
  val_t                 head_value;
  val_t                 tail_value;

  val_t         model_list[$];
  list_result_t expected_q[$];
  list_result_t oldest_want;

  bit quiet = 1'b0;
  int fail_count = 0;
  int results_seen = 0;
  int n_append = 0, n_pop = 0, n_delete = 0, n_none = 0;
  int n_full = 0, n_miss = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit stall_next = 1'b0;

  ordered_list_append_remove u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .entry_count(entry_count),
    .head_value (head_value),
    .tail_value (tail_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one operation to the list model and returns what the block reports.
  function automatic list_result_t predict_list_op(op_t code, val_t v);
    list_result_t r;
    int           hit;
    r.status = ST_MISS;
    hit = -1;
    case (code)
      OP_APPEND: begin
        if (model_list.size() >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          model_list.push_back(v);
          r.status = ST_DONE;
        end
      end
      OP_POP: begin
        if (model_list.size() > 0) begin
          void'(model_list.pop_front());
          r.status = ST_DONE;
        end
      end
      OP_DELETE: begin
        for (int i = 0; i < model_list.size() && hit < 0; i++) begin
          if (model_list[i] == v) hit = i;
        end
        if (hit >= 0) begin
          model_list.delete(hit);
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.count = CountOutW'(model_list.size());
    if (model_list.size() > 0) begin
      r.head = model_list[0];
      r.tail = model_list[model_list.size() - 1];
    end else begin
      r.head = '0;
      r.tail = '0;
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 40);
  endfunction

  function automatic val_t rand_val();
    case ($urandom_range(0, 19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return val_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [OpW-1:0] code, input val_t v);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    op         <= code;
    item_value <= v;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_list_op(op_t'(code), v));
    case (op_t'(code))
      OP_APPEND: n_append++;
      OP_POP:    n_pop++;
      OP_DELETE: n_delete++;
      default:   n_none++;
    endcase
  endtask

  // Result side stall: alternating segments, stall segments mostly short.
  always @(negedge clk) begin
    if (hold_left == 0) begin
      stall_next = ($urandom_range(0, 99) < 35);
      hold_left  = stall_next ? idle_len() + 1 : $urandom_range(1, 8);
    end
    hold_left--;
    out_stall <= quiet ? 1'b0 : stall_next;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: status %0d count %0d", status, entry_count);
        fail_count++;
      end else begin
        oldest_want = expected_q.pop_front();
        results_seen++;
        if (oldest_want.status == ST_FULL) n_full++;
        if (oldest_want.status == ST_MISS) n_miss++;
        if (status !== oldest_want.status) begin
          $error("status: expected %0d, got %0d", oldest_want.status, status);
          fail_count++;
        end
        if (entry_count !== oldest_want.count) begin
          $error("entry_count: expected %0d, got %0d", oldest_want.count, entry_count);
          fail_count++;
        end
        if (head_value !== oldest_want.head) begin
          $error("head_value: expected %0d, got %0d", oldest_want.head, head_value);
          fail_count++;
        end
        if (tail_value !== oldest_want.tail) begin
          $error("tail_value: expected %0d, got %0d", oldest_want.tail, tail_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no item moved for %0d cycles", IdleLimit);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_empty_list();
    send_item(OP_POP, 32'sd0);
    send_item(OP_DELETE, 32'sd5);
    send_item(OP_NONE, '1);
  endtask

  // Leaves a single entry (max positive) behind.
  task automatic test_extreme_values();
    send_item(OP_APPEND, 32'sh8000_0000);
    send_item(OP_APPEND, 32'sh7fff_ffff);
    send_item(OP_APPEND, 32'sd0);
    send_item(OP_APPEND, -32'sd1);
    send_item(OP_DELETE, 32'sd7);
    send_item(OP_DELETE, 32'sd0);
    send_item(OP_DELETE, 32'sh8000_0000);
    send_item(OP_DELETE, -32'sd1);
    send_item(OP_NONE, 32'sd0);
  endtask

  // Fill with alternating values, overflow, then remove a duplicate: only the
  // first match may go, so the tail stays the same value.
  task automatic test_full_list();
    val_t pat_a, pat_b;
    pat_a = 32'sh5555_5555;
    pat_b = 32'shaaaa_aaaa;
    for (int i = 0; i < Capacity - 1; i++) send_item(OP_APPEND, (i % 2 == 0) ? pat_a : pat_b);
    send_item(OP_APPEND, 32'sh0f0f_0f0f);
    send_item(OP_DELETE, pat_a);
  endtask

  task automatic test_random_traffic(input int n_items);
    int             sent, burst, mode, p_append, r;
    logic [OpW-1:0] code;
    val_t           v;
    val_t           pool[6];
    sent = 0;
    while (sent < n_items) begin
      mode  = $urandom_range(0, 3);
      burst = $urandom_range(20, 120);
      quiet = ($urandom_range(0, 4) == 0);
      foreach (pool[k]) pool[k] = rand_val();
      case (mode)
        0:       p_append = 75;
        1:       p_append = 20;
        default: p_append = 45;
      endcase
      for (int j = 0; j < burst && sent < n_items; j++) begin
        r = $urandom_range(0, 99);
        if (r < p_append) begin
          code = OP_APPEND;
          v = (mode != 3 && $urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 5)]
                                                         : rand_val();
        end else begin
          r = $urandom_range(0, 99);
          if (r < 30) begin
            code = OP_POP;
            v    = rand_val();
          end else if (r < 95) begin
            code = OP_DELETE;
            if (model_list.size() > 0 && $urandom_range(0, 9) < 7)
              v = model_list[$urandom_range(0, model_list.size() - 1)];
            else if (mode != 3)
              v = pool[$urandom_range(0, 5)];
            else
              v = rand_val();
          end else begin
            code = OP_NONE;
            v    = rand_val();
          end
        end
        send_item(code, v);
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_extreme_values();
    test_full_list();
    test_random_traffic(RandomSize);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      fail_count++;
    end

    $display("Run covered %0d appends, %0d head removals, %0d value removals, %0d unused codes",
             n_append, n_pop, n_delete, n_none);
    $display("%0d results checked, %0d with the store full, %0d with nothing removed",
             results_seen, n_full, n_miss);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
